### src/zdss_pkg.sv
// Package for the ZNCC disparity seed search block.
// Holds the shared constants, default sizes, register indexes and types.
// No dependencies.
`timescale 1ns / 1ps

package zdss_pkg;

  // Default sizes for the top level parameters.
  localparam int MAX_WIDTH_DEF   = 1024;
  localparam int WINDOW_SIZE_DEF = 9;
  localparam int MAX_CAND_DEF    = 32;

  // Operand width of the shared multipliers and product width.
  localparam int MUL_W  = 32;
  localparam int PROD_W = 64;

  // Configuration port.
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_NCC_THRESHOLD = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DISP_MIN      = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DISP_MAX      = 2'd3;

  // Register reset values.
  localparam logic [10:0]        IMAGE_WIDTH_RST   = 11'd640;
  localparam logic signed [15:0] NCC_THRESHOLD_RST = 16'sd15565;
  localparam logic signed [6:0]  DISP_MIN_RST      = -7'sd30;
  localparam logic signed [6:0]  DISP_MAX_RST      = -7'sd7;

  // Correlation result in Q2.14.
  typedef logic signed [15:0] ncc_t;
  localparam ncc_t NCC_MIN = -16'sd16384;
  localparam logic [14:0] NCC_ONE = 15'd16384;

  // Signed correlation numerator.
  typedef logic signed [MUL_W:0] corr_t;

endpackage

### src/zdss_if.sv
// Handshake interfaces for the input pixel channel and the result channel.
// Depends on nothing but the signal widths of the block's fields.
`timescale 1ns / 1ps

interface zdss_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] left_pixel;
  logic [7:0] right_pixel;
  logic       frame_start;

  modport source(output valid, output left_pixel, output right_pixel, output frame_start,
                 input ready);
  modport sink(input valid, input left_pixel, input right_pixel, input frame_start,
               output ready);
endinterface

interface zdss_out_if;
  logic              valid;
  logic              ready;
  logic              window_valid;
  logic signed [7:0] disparity;
  logic              is_seed;
  logic signed [15:0] best_ncc;

  modport source(output valid, output window_valid, output disparity, output is_seed,
                 output best_ncc, input ready);
  modport sink(input valid, input window_valid, input disparity, input is_seed,
               input best_ncc, output ready);
endinterface

### src/zdss_ncc.sv
// Serial NCC evaluator: rounds c / sqrt(a*b) to Q2.14 by a bisection search.
// Depends on zdss_pkg.
`timescale 1ns / 1ps

module zdss_ncc (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [zdss_pkg::MUL_W-1:0]  a,
  input  logic [zdss_pkg::MUL_W-1:0]  b,
  input  zdss_pkg::corr_t             c,
  output logic                        done,
  output zdss_pkg::ncc_t              q
);

  typedef enum logic [2:0] {
    S_IDLE, S_AB, S_MAG, S_RHS, S_LOOP, S_T2, S_P0, S_P1
  } state_t;

  state_t                         state_r;
  logic [zdss_pkg::MUL_W-1:0]     a_r, b_r, mag_r;
  logic                           neg_r;
  logic [zdss_pkg::PROD_W-1:0]    prod_r, ab_r, p0_r;
  logic [zdss_pkg::PROD_W+29:0]   rhs_r;
  logic [29:0]                    t2_r;
  logic [14:0]                    lo_r, hi_r, mid_r;
  logic                           done_r;
  zdss_pkg::ncc_t                 q_r;

  logic [zdss_pkg::MUL_W-1:0]     mx, my;
  logic [15:0]                    mid_sum;
  logic [14:0]                    mid;
  logic [15:0]                    t_full;
  logic [zdss_pkg::PROD_W+31:0]   lhs;
  logic [zdss_pkg::MUL_W:0]       c_abs;

  always_comb begin
    mid_sum = 16'(lo_r) + 16'(hi_r) + 16'd1;
    mid     = mid_sum[15:1];
    t_full  = {mid, 1'b0} - 16'd1;
    lhs     = {prod_r, 32'd0} + {32'd0, p0_r};
    c_abs   = c[zdss_pkg::MUL_W] ? (zdss_pkg::MUL_W+1)'(-c) : (zdss_pkg::MUL_W+1)'(c);
    unique case (state_r)
      S_AB: begin
        mx = a_r;
        my = b_r;
      end
      S_MAG: begin
        mx = mag_r;
        my = mag_r;
      end
      S_LOOP: begin
        mx = {17'd0, t_full[14:0]};
        my = {17'd0, t_full[14:0]};
      end
      S_T2: begin
        mx = ab_r[31:0];
        my = prod_r[31:0];
      end
      S_P0: begin
        mx = ab_r[63:32];
        my = {2'd0, t2_r};
      end
      default: begin
        mx = '0;
        my = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    prod_r <= zdss_pkg::PROD_W'(mx) * zdss_pkg::PROD_W'(my);
  end

  // Done pulses for one cycle, either at once for a constant patch or when
  // the bisection has closed.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      done_r <= 1'b0;
    end else begin
      done_r <= (state_r == S_IDLE && start && (a == '0 || b == '0)) ||
                (state_r == S_LOOP && !(lo_r < hi_r));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (start) begin
            a_r   <= a;
            b_r   <= b;
            neg_r <= c[zdss_pkg::MUL_W];
            mag_r <= c_abs[zdss_pkg::MUL_W-1:0];
            lo_r  <= '0;
            hi_r  <= zdss_pkg::NCC_ONE;
            if (a == '0 || b == '0) begin
              // A constant patch gives a correlation of zero.
              q_r <= '0;
            end else begin
              state_r <= S_AB;
            end
          end
        end
        S_AB: state_r <= S_MAG;
        S_MAG: begin
          ab_r    <= prod_r;
          state_r <= S_RHS;
        end
        S_RHS: begin
          rhs_r   <= {prod_r, 30'd0};
          state_r <= S_LOOP;
        end
        S_LOOP: begin
          if (lo_r < hi_r) begin
            mid_r   <= mid;
            state_r <= S_T2;
          end else begin
            q_r     <= neg_r ? -$signed({1'b0, lo_r}) : $signed({1'b0, lo_r});
            state_r <= S_IDLE;
          end
        end
        S_T2: begin
          t2_r    <= prod_r[29:0];
          state_r <= S_P0;
        end
        S_P0: begin
          p0_r    <= prod_r;
          state_r <= S_P1;
        end
        S_P1: begin
          // Keep mid when (2*mid-1)^2 * a*b does not exceed c^2 * 2^30.
          if (lhs <= {2'd0, rhs_r}) lo_r <= mid_r;
          else                      hi_r <= mid_r - 15'd1;
          state_r <= S_LOOP;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign done = done_r;
  assign q    = q_r;

endmodule

### src/zncc_disparity_seed_search.sv
// Top level of the ZNCC disparity seed search block: line stores, window
// sweep, candidate loop and result register. Depends on zdss_pkg, zdss_if
// and zdss_ncc.
`timescale 1ns / 1ps

//  Channel   Direction  Transaction contents
//  in_ch     input      left_pixel, right_pixel, frame_start
//  out_ch    output     window_valid, disparity, is_seed, best_ncc
//  cfg_*     input      image_width, ncc_threshold, disp_min, disp_max writes
//
// A pixel without a full window goes straight to the finish state. A pixel
// with a full window walks the candidates one after another; each searched
// candidate costs a sweep of the window through both line stores (one read
// port each), a drain state, the moment products and the serial NCC
// bisection. Reset is synchronous and active low; the line stores are not
// cleared. A new pixel is taken while the previous result still waits in
// the output register; the block stalls only when a second result is ready
// and the first has not been taken.

module zncc_disparity_seed_search #(
  parameter int MAX_WIDTH      = zdss_pkg::MAX_WIDTH_DEF,
  parameter int WINDOW_SIZE    = zdss_pkg::WINDOW_SIZE_DEF,
  parameter int MAX_CANDIDATES = zdss_pkg::MAX_CAND_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  zdss_in_if.sink                              in_ch,
  zdss_out_if.source                           out_ch,
  input  logic                                 cfg_we,
  input  logic [zdss_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [zdss_pkg::CFG_DATA_W-1:0]      cfg_wdata
);

  localparam int NPIX      = WINDOW_SIZE * WINDOW_SIZE;
  localparam int CW        = $clog2(MAX_WIDTH + 1);
  localparam int SLW       = $clog2(WINDOW_SIZE);
  localparam int MEM_DEPTH = WINDOW_SIZE * MAX_WIDTH;
  localparam int AWM       = $clog2(MEM_DEPTH);
  localparam int S1W       = $clog2(NPIX * 255 + 1);
  localparam int S2W       = $clog2(NPIX * 65025 + 1);
  localparam int RW        = CW + 2;
  localparam int MW        = zdss_pkg::MUL_W;

  typedef enum logic [3:0] {
    S_IDLE, S_CAND, S_SWEEP, S_DRAIN, S_M1, S_M2, S_M3, S_M4, S_NCC, S_FINISH
  } state_t;

  // Configuration registers.
  logic [10:0]        width_r;
  logic signed [15:0] thr_r;
  logic signed [6:0]  dmin_r, dmax_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r <= zdss_pkg::IMAGE_WIDTH_RST;
      thr_r   <= zdss_pkg::NCC_THRESHOLD_RST;
      dmin_r  <= zdss_pkg::DISP_MIN_RST;
      dmax_r  <= zdss_pkg::DISP_MAX_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        zdss_pkg::CFG_IMAGE_WIDTH:   width_r <= cfg_wdata[10:0];
        zdss_pkg::CFG_NCC_THRESHOLD: thr_r   <= $signed(cfg_wdata);
        zdss_pkg::CFG_DISP_MIN:      dmin_r  <= $signed(cfg_wdata[6:0]);
        zdss_pkg::CFG_DISP_MAX:      dmax_r  <= $signed(cfg_wdata[6:0]);
      endcase
    end
  end

  state_t                  state_r;
  logic [CW-1:0]           col_cnt_r, cur_col_r;
  logic [9:0]              row_cnt_r;
  logic [SLW-1:0]          slot_cnt_r, cur_slot_r;
  logic                    win_r;
  logic signed [7:0]       d_r, best_d_r;
  zdss_pkg::ncc_t          best_r;
  logic                    taken_r;
  logic [SLW-1:0]          k_r, j_r, rk_r;
  logic [AWM-1:0]          rbase_r;
  logic                    rd_vld_r;
  logic [MW-1:0]           a_r, b_r;
  zdss_pkg::corr_t         c_r;
  logic                    ncc_start_r;
  logic [zdss_pkg::PROD_W-1:0] prod_r;

  logic                    out_valid_r, out_win_r, out_seed_r;
  logic signed [7:0]       out_disp_r;
  zdss_pkg::ncc_t          out_ncc_r;

  logic [S1W-1:0]          s1_r, s2_r;
  logic [S2W-1:0]          s11_r, s22_r, s12_r;
  logic [7:0]              lq_r, rq_r;

  // The accepted pixel's position, after a frame start or width change.
  logic [CW-1:0]           effw, col_base, col_sel, col_inc;
  logic [9:0]              row_base;
  logic [SLW-1:0]          slot_base, slot_inc, sweep_slot;
  logic                    win_ok, wrap, accept;
  logic [AWM-1:0]          wr_addr, rd_addr_l, rd_addr_r;
  logic signed [RW-1:0]    rc0;
  logic [CW-1:0]           lcol0;
  logic signed [7:0]       dmin_ext, dmax_ext, dlim, dlast;
  logic [MW-1:0]           mx, my;
  logic                    ncc_done;
  zdss_pkg::ncc_t          ncc_q;

  assign accept = in_ch.valid && in_ch.ready;

  always_comb begin
    if (width_r == '0)                    effw = CW'(1);
    else if (int'(width_r) > MAX_WIDTH)   effw = CW'(MAX_WIDTH);
    else                                  effw = CW'(width_r);

    col_base  = in_ch.frame_start ? '0 : col_cnt_r;
    row_base  = in_ch.frame_start ? '0 : row_cnt_r;
    slot_base = in_ch.frame_start ? '0 : slot_cnt_r;
    col_sel   = (col_base >= effw) ? '0 : col_base;
    col_inc   = col_sel + CW'(1);
    wrap      = (col_inc >= effw);
    slot_inc  = (slot_base == SLW'(WINDOW_SIZE - 1)) ? '0 : slot_base + SLW'(1);
    win_ok    = (row_base >= 10'(WINDOW_SIZE - 1)) && (col_sel >= CW'(WINDOW_SIZE - 1));
    wr_addr   = AWM'(int'(slot_base) * MAX_WIDTH + int'(col_sel));

    // The oldest stored row sits one slot after the current one.
    sweep_slot = (cur_slot_r == SLW'(WINDOW_SIZE - 1)) ? '0 : cur_slot_r + SLW'(1);

    dmin_ext = 8'(dmin_r);
    dmax_ext = 8'(dmax_r);
    dlim     = dmin_ext + 8'(MAX_CANDIDATES - 1);
    dlast    = (dmax_ext > dlim) ? dlim : dmax_ext;

    // Left edge of the right window for the current candidate.
    rc0       = $signed({2'b00, cur_col_r}) + RW'(d_r) - RW'(WINDOW_SIZE - 1);
    lcol0     = cur_col_r - CW'(WINDOW_SIZE - 1);
    rd_addr_l = AWM'(int'(rbase_r) + int'(lcol0) + int'(j_r));
    rd_addr_r = AWM'(int'(rbase_r) + int'(rc0[CW-1:0]) + int'(j_r));
  end

  // Line stores: written once per accepted pixel, read during the sweep.
  logic [7:0] lmem [MEM_DEPTH];
  logic [7:0] rmem [MEM_DEPTH];

  always_ff @(posedge clk) begin
    if (accept) begin
      lmem[wr_addr] <= in_ch.left_pixel;
      rmem[wr_addr] <= in_ch.right_pixel;
    end
    lq_r <= lmem[rd_addr_l];
    rq_r <= rmem[rd_addr_r];
  end

  // Window moments, summed as the read data returns.
  always_ff @(posedge clk) begin
    if (state_r == S_CAND) begin
      s1_r  <= '0;
      s2_r  <= '0;
      s11_r <= '0;
      s22_r <= '0;
      s12_r <= '0;
    end else if (rd_vld_r) begin
      s1_r  <= s1_r + S1W'(lq_r);
      s2_r  <= s2_r + S1W'(rq_r);
      s11_r <= s11_r + S2W'(16'(lq_r) * 16'(lq_r));
      s22_r <= s22_r + S2W'(16'(rq_r) * 16'(rq_r));
      s12_r <= s12_r + S2W'(16'(lq_r) * 16'(rq_r));
    end
  end

  // One shared multiplier for the moment products.
  always_comb begin
    unique case (state_r)
      S_M1: begin
        mx = MW'(s1_r);
        my = MW'(s1_r);
      end
      S_M2: begin
        mx = MW'(s2_r);
        my = MW'(s2_r);
      end
      S_M3: begin
        mx = MW'(s1_r);
        my = MW'(s2_r);
      end
      default: begin
        mx = '0;
        my = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    prod_r <= zdss_pkg::PROD_W'(mx) * zdss_pkg::PROD_W'(my);
  end

  zdss_ncc u_ncc (
    .clk   (clk),
    .rst_n (rst_n),
    .start (ncc_start_r),
    .a     (a_r),
    .b     (b_r),
    .c     (c_r),
    .done  (ncc_done),
    .q     (ncc_q)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      col_cnt_r   <= '0;
      row_cnt_r   <= '0;
      slot_cnt_r  <= '0;
      rd_vld_r    <= 1'b0;
      ncc_start_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      rd_vld_r    <= (state_r == S_SWEEP);
      // The evaluator starts once the numerator is formed.
      ncc_start_r <= (state_r == S_M4);
      // The finish state loads the output register itself.
      if (out_valid_r && out_ch.ready && state_r != S_FINISH) out_valid_r <= 1'b0;

      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            cur_col_r  <= col_sel;
            cur_slot_r <= slot_base;
            win_r      <= win_ok;
            d_r        <= 8'(dmin_r);
            best_r     <= zdss_pkg::NCC_MIN;
            best_d_r   <= '0;
            taken_r    <= 1'b0;
            if (wrap) begin
              col_cnt_r  <= '0;
              row_cnt_r  <= row_base + 10'd1;
              slot_cnt_r <= slot_inc;
            end else begin
              col_cnt_r  <= col_inc;
              row_cnt_r  <= row_base;
              slot_cnt_r <= slot_base;
            end
            state_r <= win_ok ? S_CAND : S_FINISH;
          end
        end
        S_CAND: begin
          if (d_r > dlast) begin
            state_r <= S_FINISH;
          end else if (d_r > 8'sd0 || rc0 < 0) begin
            // Positive disparities are skipped, as is a right window that would leave the image.
            d_r <= d_r + 8'sd1;
          end else begin
            k_r     <= '0;
            j_r     <= '0;
            rk_r    <= sweep_slot;
            rbase_r <= AWM'(int'(sweep_slot) * MAX_WIDTH);
            state_r <= S_SWEEP;
          end
        end
        S_SWEEP: begin
          if (j_r == SLW'(WINDOW_SIZE - 1)) begin
            j_r <= '0;
            k_r <= k_r + SLW'(1);
            if (rk_r == SLW'(WINDOW_SIZE - 1)) begin
              rk_r    <= '0;
              rbase_r <= '0;
            end else begin
              rk_r    <= rk_r + SLW'(1);
              rbase_r <= AWM'(int'(rbase_r) + MAX_WIDTH);
            end
            if (k_r == SLW'(WINDOW_SIZE - 1)) state_r <= S_DRAIN;
          end else begin
            j_r <= j_r + SLW'(1);
          end
        end
        S_DRAIN: state_r <= S_M1;
        S_M1:    state_r <= S_M2;
        S_M2: begin
          a_r     <= MW'(zdss_pkg::PROD_W'(NPIX) * zdss_pkg::PROD_W'(s11_r) - prod_r);
          state_r <= S_M3;
        end
        S_M3: begin
          b_r     <= MW'(zdss_pkg::PROD_W'(NPIX) * zdss_pkg::PROD_W'(s22_r) - prod_r);
          state_r <= S_M4;
        end
        S_M4: begin
          c_r <= (MW+1)'($signed({1'b0, zdss_pkg::PROD_W'(NPIX) * zdss_pkg::PROD_W'(s12_r)})
                         - $signed({1'b0, prod_r}));
          state_r <= S_NCC;
        end
        S_NCC: begin
          if (ncc_done) begin
            // Strictly greater keeps the smallest disparity on a tie.
            if (ncc_q > best_r) begin
              best_r   <= ncc_q;
              best_d_r <= d_r;
              taken_r  <= 1'b1;
            end
            d_r     <= d_r + 8'sd1;
            state_r <= S_CAND;
          end
        end
        S_FINISH: begin
          if (!out_valid_r || out_ch.ready) begin
            out_valid_r <= 1'b1;
            out_win_r   <= win_r;
            if (!win_r) begin
              out_disp_r <= '0;
              out_seed_r <= 1'b0;
              out_ncc_r  <= '0;
            end else if (taken_r && best_r > thr_r) begin
              out_disp_r <= best_d_r;
              out_seed_r <= 1'b1;
              out_ncc_r  <= best_r;
            end else begin
              out_disp_r <= dmin_ext - 8'sd1;
              out_seed_r <= 1'b0;
              out_ncc_r  <= best_r;
            end
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_ch.ready         = (state_r == S_IDLE);
  assign out_ch.valid        = out_valid_r;
  assign out_ch.window_valid = out_win_r;
  assign out_ch.disparity    = out_disp_r;
  assign out_ch.is_seed      = out_seed_r;
  assign out_ch.best_ncc     = out_ncc_r;

endmodule

### tb/zdss_checker.sv
// Checker for the ZNCC disparity seed search block: watches the pixel, result
// and register channels, predicts each result and compares it field by field.
// Depends on zdss_pkg and the zdss_in_if / zdss_out_if interfaces.
`timescale 1ns / 1ps

module zdss_checker (
  input  logic                                clk,
  input  logic                                rst_n,
  zdss_in_if                                  in_ch,
  zdss_out_if                                 out_ch,
  input  logic                                cfg_we,
  input  logic [zdss_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [zdss_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  output int                                  fail_count,
  output int                                  pending
);
  import zdss_pkg::*;

  localparam int WIN  = WINDOW_SIZE_DEF;
  localparam int HALF = (WIN - 1) / 2;
  localparam int NPIX = WIN * WIN;
  localparam int MAXW = MAX_WIDTH_DEF;

  typedef struct packed {
    logic              window_valid;
    logic signed [7:0] disparity;
    logic              is_seed;
    ncc_t              best_ncc;
  } seed_result_t;

  seed_result_t seed_q[$];

  logic [7:0] left_rows  [WIN*MAXW];
  logic [7:0] right_rows [WIN*MAXW];
  int unsigned col_pos, row_pos, slot;

  logic [10:0]        width_reg;
  logic signed [15:0] thresh_reg;
  logic signed [6:0]  dmin_reg, dmax_reg;

  initial fail_count = 0;
  initial pending = 0;

  // Q2.14 correlation rounded to nearest, halves away from zero, by bisection.
  function automatic ncc_t corr_q14(longint c, longint unsigned a, longint unsigned b);
    logic [127:0] ab, rhs, lhs, t;
    longint unsigned mag;
    int unsigned lo, hi, mid;
    if (a == 0 || b == 0) return '0;
    mag = (c < 0) ? longint'(-c) : longint'(c);
    ab  = 128'(a) * 128'(b);
    rhs = (128'(mag) * 128'(mag)) << 30;
    lo = 0;
    hi = 16384;
    while (lo < hi) begin
      mid = (lo + hi + 1) / 2;
      t   = 128'(2 * mid - 1);
      lhs = t * t * ab;
      if (lhs <= rhs) lo = mid;
      else hi = mid - 1;
    end
    return (c < 0) ? -ncc_t'(lo) : ncc_t'(lo);
  endfunction

  // Stores the pixel pair and searches the disparities for the window centre.
  function automatic seed_result_t search_seed(logic [7:0] lpx, logic [7:0] rpx, logic fs);
    seed_result_t res;
    int unsigned effw, col, base [WIN];
    longint s1, s11, s2, s22, s12, a, b, c;
    int best, best_d, d, dlast, x, rc0, q;
    bit taken;
    effw = (width_reg < 1) ? 1 : ((width_reg > MAXW) ? MAXW : width_reg);
    if (fs) begin
      col_pos = 0;
      row_pos = 0;
      slot = 0;
    end
    if (col_pos >= effw) col_pos = 0;
    col = col_pos;
    left_rows[slot*MAXW + col]  = lpx;
    right_rows[slot*MAXW + col] = rpx;
    res = '0;
    if (row_pos >= WIN - 1 && col >= WIN - 1) begin
      x = int'(col) - HALF;
      s1 = 0;
      s11 = 0;
      for (int k = 0; k < WIN; k++) base[k] = ((slot + 1 + k) % WIN) * MAXW;
      for (int k = 0; k < WIN; k++)
        for (int i = 0; i < WIN; i++) begin
          s1  += left_rows[base[k] + col - (WIN-1) + i];
          s11 += left_rows[base[k] + col - (WIN-1) + i] * left_rows[base[k] + col - (WIN-1) + i];
        end
      a = NPIX * s11 - s1 * s1;
      best = -16384;
      best_d = 0;
      taken = 0;
      dlast = dmax_reg;
      if (dlast > dmin_reg + MAX_CAND_DEF - 1) dlast = dmin_reg + MAX_CAND_DEF - 1;
      for (d = dmin_reg; d <= dlast; d++) begin
        rc0 = x + d - HALF;
        if (d > 0 || rc0 < 0) continue;
        s2 = 0;
        s22 = 0;
        s12 = 0;
        for (int k = 0; k < WIN; k++)
          for (int j = 0; j < WIN; j++) begin
            longint lp, rp;
            lp = left_rows[base[k] + col - (WIN-1) + j];
            rp = right_rows[base[k] + rc0 + j];
            s2 += rp;
            s22 += rp * rp;
            s12 += lp * rp;
          end
        b = NPIX * s22 - s2 * s2;
        c = NPIX * s12 - s1 * s2;
        q = corr_q14(c, a, b);
        if (q > best) begin
          best = q;
          best_d = d;
          taken = 1;
        end
      end
      res.window_valid = 1'b1;
      if (taken && best > thresh_reg) begin
        res.disparity = 8'(best_d);
        res.is_seed = 1'b1;
      end else begin
        res.disparity = 8'(int'(dmin_reg) - 1);
      end
      res.best_ncc = ncc_t'(best);
    end
    col_pos = col + 1;
    if (col_pos >= effw) begin
      col_pos = 0;
      row_pos = (row_pos + 1) & 10'h3FF;
      slot = (slot + 1) % WIN;
    end
    return res;
  endfunction

  always @(posedge clk) begin
    seed_result_t got, want;
    if (!rst_n) begin
      seed_q.delete();
      col_pos = 0;
      row_pos = 0;
      slot = 0;
      width_reg = IMAGE_WIDTH_RST;
      thresh_reg = NCC_THRESHOLD_RST;
      dmin_reg = DISP_MIN_RST;
      dmax_reg = DISP_MAX_RST;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_IMAGE_WIDTH:   width_reg = cfg_wdata[10:0];
          CFG_NCC_THRESHOLD: thresh_reg = cfg_wdata;
          CFG_DISP_MIN:      dmin_reg = cfg_wdata[6:0];
          CFG_DISP_MAX:      dmax_reg = cfg_wdata[6:0];
          default: ;
        endcase
      end
      if (in_ch.valid && in_ch.ready)
        seed_q = {seed_q, search_seed(in_ch.left_pixel, in_ch.right_pixel, in_ch.frame_start)};
      if (out_ch.valid && out_ch.ready) begin
        got = {out_ch.window_valid, out_ch.disparity, out_ch.is_seed, out_ch.best_ncc};
        if (seed_q.size() == 0) begin
          fail_count++;
          $display("%0t: unexpected result transaction %p", $time, got);
        end else begin
          want = seed_q.pop_front();
          if (got.window_valid !== want.window_valid || got.disparity !== want.disparity ||
              got.is_seed !== want.is_seed || got.best_ncc !== want.best_ncc) begin
            fail_count++;
            $display("%0t: mismatch expected wv=%0d disp=%0d seed=%0d ncc=%0d", $time,
                     want.window_valid, want.disparity, want.is_seed, want.best_ncc);
            $display("%0t:          actual   wv=%0d disp=%0d seed=%0d ncc=%0d", $time,
                     got.window_valid, got.disparity, got.is_seed, got.best_ncc);
          end
        end
      end
    end
    pending = seed_q.size();
  end

endmodule

### tb/zncc_disparity_seed_search_tb.sv
// Testbench top for the ZNCC disparity seed search block: clock, reset,
// pixel stimulus, result back-pressure, register writes and the verdict.
// Depends on zdss_pkg, the zdss interfaces, the block and zdss_checker.
`timescale 1ns / 1ps

module zncc_disparity_seed_search_tb;
  import zdss_pkg::*;

  // Image content kinds used to steer the correlation toward its corners.
  // The banded kind has a constant left band on the right side of each row
  // and a constant right band on the left side, so both zero denominators
  // show up in one frame.
  typedef enum int {TEX_MATCH, TEX_NOISE, TEX_BANDS} tex_kind_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  int fail_count, pending;
  int quiet_cycles;
  bit hold_req, no_idle;
  int unsigned tex_seed;

  zdss_in_if  in_ch();
  zdss_out_if out_ch();

  zncc_disparity_seed_search u_top (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  zdss_checker u_checker (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .fail_count(fail_count), .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // A pixel searches at most 32 candidates, so a quiet stretch that trips
  // this watchdog can only mean the block has hung.
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= 20000) begin
      $display("zncc_disparity_seed_search regression: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Hashed texture so that the right image can be a shifted copy of the left.
  function automatic logic [7:0] texel(int r, int c);
    int unsigned h;
    h = (r * 7919 + c * 104729 + tex_seed) * 32'd2654435761;
    return h[31:24];
  endfunction

  // One pixel transaction; entered and left at a falling edge.
  task automatic send_pixel(logic [7:0] lpx, logic [7:0] rpx, logic fs);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      in_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid = 1'b1;
    in_ch.left_pixel = lpx;
    in_ch.right_pixel = rpx;
    in_ch.frame_start = fs;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
    in_ch.frame_start = 1'b0;
  endtask

  // Registers may only change while the block is idle. Every pixel yields one
  // result, so once nothing is pending a short pause is enough.
  task automatic wait_idle();
    in_ch.valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (10) @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_wdata = value;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // Writes all four registers and streams part of a frame. The width is the
  // raw register value, so out-of-range widths exercise the clamp. A shift of
  // d makes right(c) = left(c - d), which the search should find at d. A part
  // that starts at row 0 begins a new frame; a later row continues the frame
  // at the same width, so new register values apply to full windows at once.
  // With restarts set, a new frame start is occasionally injected mid-frame.
  task automatic run_frame(int width, int thresh, int dmin, int dmax, int first_row,
                           int n_items, tex_kind_t kind, int shift, bit restarts);
    int effw, r, c;
    logic [7:0] lpx, rpx;
    logic fs;
    wait_idle();
    write_reg(CFG_IMAGE_WIDTH, CFG_DATA_W'(width));
    write_reg(CFG_NCC_THRESHOLD, CFG_DATA_W'(thresh));
    write_reg(CFG_DISP_MIN, CFG_DATA_W'(dmin & 7'h7F));
    write_reg(CFG_DISP_MAX, CFG_DATA_W'(dmax & 7'h7F));
    effw = (width < 1) ? 1 : ((width > MAX_WIDTH_DEF) ? MAX_WIDTH_DEF : width);
    if (first_row == 0) tex_seed = $urandom;
    no_idle = ($urandom_range(0, 3) == 0);
    for (int i = 0; i < n_items; i++) begin
      r = first_row + i / effw;
      c = i % effw;
      fs = (i == 0 && first_row == 0) || (restarts && $urandom_range(0, 79) == 0);
      case (kind)
        TEX_MATCH: begin
          lpx = texel(r, c);
          rpx = ($urandom_range(0, 30) == 0) ? 8'($urandom) : texel(r, c - shift);
        end
        TEX_NOISE: begin
          lpx = 8'($urandom);
          rpx = 8'($urandom);
        end
        default: begin
          lpx = (c >= 10) ? 8'd77 : texel(r, c);
          rpx = (c <= 8) ? 8'd255 : texel(r, c - shift);
        end
      endcase
      send_pixel(lpx, rpx, fs);
    end
  endtask

  // Result side: random stalls per transaction, plus one long hold-off on
  // request so the output register and the pipeline fill and stall the input.
  initial begin
    int stall;
    out_ch.ready = 1'b0;
    @(posedge rst_n);
    @(negedge clk);
    forever begin
      if (hold_req) begin
        out_ch.ready = 1'b0;
        repeat (600) @(negedge clk);
        hold_req = 1'b0;
      end
      stall = no_idle ? 0 : $urandom_range(0, 3);
      if (stall > 0) begin
        out_ch.ready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ch.ready = 1'b1;
      do @(posedge clk); while (!out_ch.valid);
      @(negedge clk);
    end
  end

  initial begin
    int dmin;
    in_ch.valid = 1'b0;
    in_ch.left_pixel = '0;
    in_ch.right_pixel = '0;
    in_ch.frame_start = 1'b0;
    cfg_we = 1'b0;
    cfg_index = CFG_IMAGE_WIDTH;
    cfg_wdata = '0;
    hold_req = 1'b0;
    no_idle = 1'b0;
    quiet_cycles = 0;
    tex_seed = 0;
    rst_n = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Banded frame with a long output hold-off first: constant left and right
    // patches, and a positive candidate that is skipped.
    hold_req = 1'b1;
    run_frame(19, 15565, -3, 1, 0, 19 * 10, TEX_BANDS, -2, 0);
    // Every candidate falls off the left edge, so none is taken.
    run_frame(19, 0, -64, -60, 10, 19 * 2, TEX_NOISE, 0, 0);
    // Empty disparity range.
    run_frame(19, 100, 0, -5, 12, 19, TEX_NOISE, 0, 0);
    // A positive lower bound searches nothing and reports disp_min-1 above 0.
    run_frame(19, 0, 3, 63, 13, 19, TEX_NOISE, 0, 0);
    // Range wider than the candidate limit at the lowest threshold.
    run_frame(19, -16384, -40, 0, 14, 19 * 2, TEX_MATCH, -2, 0);

    // Random rows, mostly shifted copies, with frame restarts mixed in.
    for (int f = 0; f < 2; f++) begin
      dmin = -int'($urandom_range(0, 6));
      run_frame(19, ($urandom_range(0, 1) == 0) ? int'($urandom_range(13000, 16000))
                                                : int'($urandom_range(0, 32768)) - 16384,
                dmin, dmin + int'($urandom_range(0, 3)), 16 + f, 19,
                ($urandom_range(0, 3) == 0) ? TEX_NOISE : TEX_MATCH,
                -int'($urandom_range(0, 6)), 1);
    end

    // Width clamps: zero acts as one, an oversize width as the line maximum.
    run_frame(0, 0, -1, 0, 0, 12, TEX_NOISE, 0, 0);
    run_frame(2047, 0, -1, 0, 0, 30, TEX_NOISE, 0, 0);

    // Back to the reset-like register values before the drain.
    run_frame(640, 15565, -30, -7, 0, 20, TEX_NOISE, 0, 0);

    in_ch.valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    if (fail_count == 0) begin
      $display("zncc_disparity_seed_search regression: pass");
    end else begin
      $display("zncc_disparity_seed_search regression: fail");
    end
    $finish;
  end

endmodule

### sim.f
src/zdss_pkg.sv
src/zdss_if.sv
src/zdss_ncc.sv
src/zncc_disparity_seed_search.sv
tb/zdss_checker.sv
tb/zncc_disparity_seed_search_tb.sv
